// ----- rtl/frame_buffer_line_circle_plotter_macros.svh -----
// Assertion macros for the plotter RTL, used by the frame store.
`ifndef FRAME_BUFFER_LINE_CIRCLE_PLOTTER_MACROS_SVH
`define FRAME_BUFFER_LINE_CIRCLE_PLOTTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define FBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/fblcp_pkg.sv -----
// Package: shared types and constants of the frame buffer plotter.
`timescale 1ns / 1ps
`default_nettype none
package fblcp_pkg;
	localparam int DefPanelWidth  = 128;
	localparam int DefPanelHeight = 64;

	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_SET    = 2'd1;
	localparam logic [1:0] MODE_TOGGLE = 2'd2;
	// Spare code, behaves as toggle.
	localparam logic [1:0] MODE_TOGGLE_ALT = 2'd3;

	// One command word.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] x_start;
		logic [7:0] y_start;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic [7:0] radius;
		logic [1:0] pixel_mode;
	} cmd_t;

	// One pixel request from the point generator to the memory port.
	typedef struct packed {
		logic       vld;
		logic [7:0] x;
		logic [7:0] y;
		logic [1:0] mode;
	} pix_t;
endpackage
`default_nettype wire

// ----- rtl/fblcp_if.sv -----
// Interfaces: valid/ready channels for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface fblcp_cmd_if;
	logic          valid;
	logic          ready;
	fblcp_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fblcp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fblcp_store.sv -----
// Frame store memory with a read-modify-write pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none
module fblcp_store #(
	parameter int PanelWidth  = fblcp_pkg::DefPanelWidth,
	parameter int PanelHeight = fblcp_pkg::DefPanelHeight
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire fblcp_pkg::pix_t pix,
	input  wire                clr_vld,
	input  wire  [$clog2(((PanelHeight + 7) / 8) * PanelWidth)-1:0] clr_addr,
	input  wire                rd_vld,
	output logic [7:0]         rd_data,
	output logic               busy
);
	import fblcp_pkg::*;
	localparam int Pages = (PanelHeight + 7) / 8;
	localparam int Depth = Pages * PanelWidth;
	localparam int AW    = $clog2(Depth);

	logic [7:0] mem [Depth];

	// Stage 0: address of the pixel.
	logic          on_panel;
	logic [AW-1:0] addr;
	assign on_panel = (32'(pix.x) < PanelWidth) && (32'(pix.y) < PanelHeight);
	assign addr = AW'(32'(pix.y[7:3]) * PanelWidth + 32'(pix.x));

	logic          vld_s1, rd_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0]    bit_s1;
	logic [1:0]    mode_s1;
	logic [7:0]    q_s1;
	logic          fwd_s1;
	logic [7:0]    wdat;
	logic [7:0]    wdat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rd_s1  <= 1'b0;
		end else begin
			vld_s1 <= pix.vld && on_panel && !rd_vld;
			rd_s1  <= rd_vld;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		bit_s1  <= pix.y[2:0];
		mode_s1 <= pix.mode;
		fwd_s1  <= vld_s1 && (addr_s1 == addr);
		q_s1    <= mem[addr];
	end

	// Modify: forward the byte just written when the same entry follows.
	logic [7:0] cur, mask;
	assign cur  = fwd_s1 ? wdat_q : q_s1;
	assign mask = 8'(1) << bit_s1;
	always_comb begin
		case (mode_s1)
			MODE_CLEAR: wdat = cur & ~mask;
			MODE_SET:   wdat = cur | mask;
			default:    wdat = cur ^ mask;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr_vld)
			mem[clr_addr] <= 8'd0;
		else if (vld_s1)
			mem[addr_s1] <= wdat;
		if (vld_s1)
			wdat_q <= wdat;
	end

	assign rd_data = q_s1;
	assign busy    = vld_s1 || rd_s1;

	`include "frame_buffer_line_circle_plotter_macros.svh"
	`FBP_ASSERT_IMPL(a_no_clr_rmw, clk, arst_n, clr_vld, !vld_s1, "clear during pixel write")
	`FBP_ASSERT_IMPL(a_rd_alone, clk, arst_n, rd_vld, !pix.vld, "read with pixel")
	`FBP_ASSERT_NEXT(a_rd_lat, clk, arst_n, rd_vld, rd_s1, "read latency")
endmodule
`default_nettype wire

// ----- rtl/fblcp_gen.sv -----
// Point generator: sequences lines, circles, clears and reads.
`timescale 1ns / 1ps
`default_nettype none
module fblcp_gen #(
	parameter int PanelWidth  = fblcp_pkg::DefPanelWidth,
	parameter int PanelHeight = fblcp_pkg::DefPanelHeight
) (
	input  wire              clk,
	input  wire              arst_n,
	fblcp_cmd_if.sink        cmd,
	fblcp_rsp_if.source      rsp,
	output fblcp_pkg::pix_t  pix,
	output logic             clr_vld,
	output logic [$clog2(((PanelHeight + 7) / 8) * PanelWidth)-1:0] clr_addr,
	output logic             rd_vld,
	input  wire  [7:0]       rd_data,
	input  wire              busy
);
	import fblcp_pkg::*;
	localparam int Depth = ((PanelHeight + 7) / 8) * PanelWidth;
	localparam int AW    = $clog2(Depth);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LINE = 3'd1;
	localparam logic [2:0] ST_CIRC = 3'd2;
	localparam logic [2:0] ST_CLR  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_DRN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]  state_q;
	cmd_t        c_q;
	// Line stepping: signed 10-bit positions, 9-bit deltas and errors.
	logic signed [9:0] cx_q, cy_q;
	logic [8:0]  dx_q, dy_q, span_q, ex_q, ey_q, k_q;
	logic        sx_q, sy_q;
	// Circle: a, b and octant index.
	logic signed [9:0] a_q, b_q;
	logic [2:0]  oct_q;
	logic [AW-1:0] ca_q;
	logic [7:0]  rdat_q;
	logic        rd_wait_q;

	// Circle loop condition and step test (products of 10-bit values).
	logic signed [20:0] bb2, rr, stepv;
	logic signed [9:0]  a1;
	assign rr    = 21'(c_q.radius) * 21'(c_q.radius);
	assign bb2   = 21'(2) * 21'(b_q) * 21'(b_q);
	assign a1    = a_q + 10'sd1;
	assign stepv = 21'(a1) * 21'(a1) + 21'(b_q) * 21'(b_q) - rr;
	logic circ_go;
	assign circ_go = (b_q >= 0) && (bb2 >= rr);

	// Circle octant point.
	logic [7:0] xc, yc, pa, pb, px, py;
	assign xc = c_q.x_start;
	assign yc = c_q.y_start;
	assign pa = a_q[7:0];
	assign pb = b_q[7:0];
	always_comb begin
		case (oct_q)
			3'd0: begin px = xc + pa; py = yc - pb; end
			3'd1: begin px = xc - pa; py = yc - pb; end
			3'd2: begin px = xc - pa; py = yc + pb; end
			3'd3: begin px = xc + pa; py = yc + pb; end
			3'd4: begin px = xc + pb; py = yc + pa; end
			3'd5: begin px = xc + pb; py = yc - pa; end
			3'd6: begin px = xc - pb; py = yc - pa; end
			default: begin px = xc - pb; py = yc + pa; end
		endcase
	end

	// Line error update.
	logic [9:0] exn, eyn;
	assign exn = 10'(ex_q) + 10'(dx_q);
	assign eyn = 10'(ey_q) + 10'(dy_q);

	// Pixel request; a read drives the address path with the held start point.
	always_comb begin
		pix = '0;
		if (state_q == ST_LINE) begin
			pix.vld = 1'b1; pix.x = cx_q[7:0]; pix.y = cy_q[7:0]; pix.mode = c_q.pixel_mode;
		end else if (state_q == ST_CIRC && circ_go) begin
			pix.vld = 1'b1; pix.x = px; pix.y = py; pix.mode = MODE_SET;
		end else if (state_q == ST_RD) begin
			pix.x = c_q.x_start; pix.y = c_q.y_start;
		end
	end

	assign cmd.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = (state_q == ST_OUT);
	assign rsp.read_data = rdat_q;
	assign clr_vld       = (state_q == ST_CLR);
	assign clr_addr      = ca_q;
	assign rd_vld        = (state_q == ST_RD) && !rd_wait_q;

	logic signed [9:0] dxs, dys;
	logic [8:0] adx, ady;
	logic rd_ok;
	logic axis;
	assign dxs = 10'(cmd.data.x_end) - 10'(cmd.data.x_start);
	assign dys = 10'(cmd.data.y_end) - 10'(cmd.data.y_start);
	assign adx = dxs[9] ? 9'(-dxs) : 9'(dxs);
	assign ady = dys[9] ? 9'(-dys) : 9'(dys);
	assign axis = (adx == 9'd0) || (ady == 9'd0);
	assign rd_ok = (32'(c_q.x_start) < PanelWidth) && (32'(c_q.y_start) < PanelHeight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			ca_q      <= '0;
			rd_wait_q <= 1'b0;
			c_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						c_q    <= cmd.data;
						rdat_q <= 8'd0;
						cx_q <= 10'(cmd.data.x_start);
						cy_q <= 10'(cmd.data.y_start);
						sx_q <= dxs[9];
						sy_q <= dys[9];
						dx_q <= adx;
						dy_q <= ady;
						span_q <= (adx > ady) ? adx : ady;
						// Axis lines start with unit error so they advance on every step
						ex_q <= axis ? 9'd1 : 9'd0;
						ey_q <= axis ? 9'd1 : 9'd0;
						k_q <= '0;
						a_q <= '0; b_q <= 10'(cmd.data.radius); oct_q <= '0;
						ca_q <= '0;
						rd_wait_q <= 1'b0;
						case (cmd.data.kind)
							KIND_LINE:   state_q <= ST_LINE;
							KIND_CIRCLE: state_q <= ST_CIRC;
							KIND_CLEAR:  state_q <= ST_DRN;
							default:     state_q <= ST_RD;
						endcase
					end
				end
				ST_LINE: begin
					// One point per cycle, span + 1 points in all
					if (k_q == span_q) begin
						state_q <= ST_DRN;
					end else begin
						k_q <= k_q + 9'd1;
						if (exn > 10'(span_q)) begin
							ex_q <= 9'(exn - 10'(span_q));
							cx_q <= sx_q ? cx_q - 10'sd1 : cx_q + 10'sd1;
						end else ex_q <= 9'(exn);
						if (eyn > 10'(span_q)) begin
							ey_q <= 9'(eyn - 10'(span_q));
							cy_q <= sy_q ? cy_q - 10'sd1 : cy_q + 10'sd1;
						end else ey_q <= 9'(eyn);
					end
				end
				ST_CIRC: begin
					if (!circ_go) state_q <= ST_DRN;
					else begin
						oct_q <= oct_q + 3'd1;
						if (oct_q == 3'd7) begin
							if (stepv > 0) b_q <= b_q - 10'sd1;
							else a_q <= a1;
						end
					end
				end
				ST_CLR: begin
					ca_q <= ca_q + AW'(1);
					if (32'(ca_q) == Depth - 1)
						state_q <= (c_q.kind == KIND_CLEAR) ? ST_OUT : ST_IDLE;
				end
				ST_RD: begin
					if (!rd_ok) state_q <= ST_OUT;
					else if (!rd_wait_q) rd_wait_q <= 1'b1;
					else if (!busy) ;
					else begin
						rdat_q  <= rd_data;
						state_q <= ST_OUT;
					end
				end
				ST_DRN: begin
					if (!busy)
						state_q <= (c_q.kind == KIND_CLEAR) ? ST_CLR : ST_OUT;
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/frame_buffer_line_circle_plotter.sv -----
// Top level: frame buffer with line and circle plotting.
`timescale 1ns / 1ps
`default_nettype none
// One command at a time; one result word per command. A line plots each of its
// points in turn, a circle the eight octant points of each step of its outline, a
// clear zeroes every store byte (1024 at the defaults), a read fetches one byte.
// After reset the store is swept to zero before the first command is taken.
// Pixels go by read-modify-write through a memory with one read and one write
// port, with forwarding between back-to-back pixels in the same byte.
module frame_buffer_line_circle_plotter #(
	parameter int PanelWidth  = fblcp_pkg::DefPanelWidth,
	parameter int PanelHeight = fblcp_pkg::DefPanelHeight
) (
	input  wire          clk,
	input  wire          arst_n,
	fblcp_cmd_if.sink    cmd,
	fblcp_rsp_if.source  rsp
);
	import fblcp_pkg::*;
	localparam int AW = $clog2(((PanelHeight + 7) / 8) * PanelWidth);

	pix_t          pix;
	logic          clr_vld, rd_vld, busy;
	logic [AW-1:0] clr_addr;
	logic [7:0]    rd_data;

	fblcp_gen #(.PanelWidth(PanelWidth), .PanelHeight(PanelHeight)) u_gen (
		.clk, .arst_n, .cmd, .rsp, .pix, .clr_vld, .clr_addr, .rd_vld, .rd_data, .busy
	);

	fblcp_store #(.PanelWidth(PanelWidth), .PanelHeight(PanelHeight)) u_store (
		.clk, .arst_n, .pix, .clr_vld, .clr_addr, .rd_vld, .rd_data, .busy
	);
endmodule
`default_nettype wire

// ----- tb/frame_buffer_line_circle_plotter_checker.sv -----
// Checker: watches the command and result channels, predicts each result word, compares.
`timescale 1ns / 1ps
`default_nettype none
module frame_buffer_line_circle_plotter_checker #(
	parameter int PanelWidth  = fblcp_pkg::DefPanelWidth,
	parameter int PanelHeight = fblcp_pkg::DefPanelHeight
) (
	input  wire        clk,
	input  wire        arst_n,
	fblcp_cmd_if.sink  cmd,
	fblcp_rsp_if.sink  rsp,
	output int         fail_count,
	output int         pending_count
);
	import fblcp_pkg::*;

	localparam int PageCount = (PanelHeight + 7) / 8;
	localparam int Depth = PageCount * PanelWidth;

	logic [7:0] pixel_bytes [Depth];
	logic [7:0] read_data_q [$];

	// Apply one pixel operation to the predicted image.
	function automatic void put_pixel(int x, int y, logic [1:0] mode);
		int idx;
		logic [7:0] bit_mask;
		if (x < 0 || y < 0 || x >= PanelWidth || y >= PanelHeight)
			return;
		idx = (y >> 3) * PanelWidth + x;
		bit_mask = 8'd1 << (y & 7);
		if (mode == MODE_CLEAR)
			pixel_bytes[idx] &= ~bit_mask;
		else if (mode == MODE_SET)
			pixel_bytes[idx] |= bit_mask;
		else
			pixel_bytes[idx] ^= bit_mask;
	endfunction

	function automatic void trace_line(int xa, int ya, int xb, int yb, logic [1:0] mode);
		int dx, dy, sx, sy, span, ex, ey, cx, cy, stp;
		if (xa == xb && ya != yb) begin
			stp = (yb >= ya) ? 1 : -1;
			cy = ya;
			forever begin
				put_pixel(xa, cy, mode);
				if (cy == yb)
					break;
				cy += stp;
			end
		end else if (ya == yb) begin
			stp = (xb >= xa) ? 1 : -1;
			cx = xa;
			forever begin
				put_pixel(cx, ya, mode);
				if (cx == xb)
					break;
				cx += stp;
			end
		end else begin
			dx = xb - xa;
			dy = yb - ya;
			sx = 1;
			sy = 1;
			if (dx < 0) begin
				sx = -1;
				dx = -dx;
			end
			if (dy < 0) begin
				sy = -1;
				dy = -dy;
			end
			span = (dx > dy) ? dx : dy;
			ex = 0;
			ey = 0;
			cx = xa;
			cy = ya;
			for (int k = 0; k <= span; k++) begin
				put_pixel(cx & 255, cy & 255, mode);
				ex += dx;
				ey += dy;
				if (ex > span) begin
					ex -= span;
					cx += sx;
				end
				if (ey > span) begin
					ey -= span;
					cy += sy;
				end
			end
		end
	endfunction

	// Eight-way symmetric outline, coordinates wrap at 8 bits.
	function automatic void trace_circle(int xc, int yc, int r);
		int a, b;
		a = 0;
		b = r;
		while (b >= 0 && 2 * b * b >= r * r) begin
			put_pixel((xc + a) & 255, (yc - b) & 255, MODE_SET);
			put_pixel((xc - a) & 255, (yc - b) & 255, MODE_SET);
			put_pixel((xc - a) & 255, (yc + b) & 255, MODE_SET);
			put_pixel((xc + a) & 255, (yc + b) & 255, MODE_SET);
			put_pixel((xc + b) & 255, (yc + a) & 255, MODE_SET);
			put_pixel((xc + b) & 255, (yc - a) & 255, MODE_SET);
			put_pixel((xc - b) & 255, (yc - a) & 255, MODE_SET);
			put_pixel((xc - b) & 255, (yc + a) & 255, MODE_SET);
			a++;
			if (a * a + b * b - r * r > 0) begin
				b--;
				a--;
			end
		end
	endfunction

	function automatic logic [7:0] run_command(cmd_t c);
		logic [7:0] rd;
		rd = 8'd0;
		case (c.kind)
			KIND_LINE: trace_line(c.x_start, c.y_start, c.x_end, c.y_end, c.pixel_mode);
			KIND_CIRCLE: trace_circle(c.x_start, c.y_start, c.radius);
			KIND_CLEAR: foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
			default: begin
				if (c.x_start < PanelWidth && c.y_start < PanelHeight)
					rd = pixel_bytes[(c.y_start >> 3) * PanelWidth + c.x_start];
			end
		endcase
		return rd;
	endfunction

	assign pending_count = read_data_q.size();

	// Predict on command words, compare on result words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
			read_data_q.delete();
			fail_count <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				read_data_q.push_back(run_command(cmd.data));
			if (rsp.valid && rsp.ready) begin
				if (read_data_q.size() == 0) begin
					$error("unexpected result word read_data=%0h", rsp.read_data);
					fail_count <= fail_count + 1;
				end else if (read_data_q[0] !== rsp.read_data) begin
					$error("read_data expected %0h actual %0h", read_data_q[0], rsp.read_data);
					fail_count <= fail_count + 1;
					void'(read_data_q.pop_front());
				end else begin
					void'(read_data_q.pop_front());
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/frame_buffer_line_circle_plotter_tb.sv -----
// Testbench top: command stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module frame_buffer_line_circle_plotter_tb;
	import fblcp_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending_count;
	int idle_cycles = 0;
	int words_sent = 0;
	int read_words = 0;
	bit hold_rsp = 1'b0;
	bit stim_done = 1'b0;

	fblcp_cmd_if cmd_ch ();
	fblcp_rsp_if rsp_ch ();

	frame_buffer_line_circle_plotter uut (.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch));

	frame_buffer_line_circle_plotter_checker chk (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Send one command word, first waiting a drawn number of cycles when gaps is set.
	task automatic send_word(cmd_t c, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		repeat (gap) @(posedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		cmd_ch.valid <= 1'b0;
		words_sent++;
		if (c.kind == KIND_READ)
			read_words++;
		// Block is busy right after a command, so waiting here with valid low costs nothing
		@(posedge clk);
	endtask

	function automatic cmd_t make_word(logic [1:0] k, int xs, int ys, int xe, int ye,
			int r, logic [1:0] m);
		cmd_t c;
		c.kind = k;
		c.x_start = 8'(xs);
		c.y_start = 8'(ys);
		c.x_end = 8'(xe);
		c.y_end = 8'(ye);
		c.radius = 8'(r);
		c.pixel_mode = m;
		return c;
	endfunction

	// Mostly on-panel coordinates, sometimes anything.
	function automatic int pick_coord(int lim);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim - 1);
	endfunction

	function automatic cmd_t random_word();
		cmd_t c;
		int sel, len;
		sel = $urandom_range(0, 99);
		c = '0;
		c.x_start = 8'(pick_coord(128));
		c.y_start = 8'(pick_coord(64));
		c.pixel_mode = 2'($urandom_range(0, 3));
		len = ($urandom_range(0, 7) == 0) ? 255 : 24;
		c.x_end = 8'((int'(c.x_start) + $urandom_range(0, 2 * len) - len) & 255);
		c.y_end = 8'((int'(c.y_start) + $urandom_range(0, 2 * len) - len) & 255);
		c.radius = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, 20));
		if (sel < 35)
			c.kind = KIND_LINE;
		else if (sel < 50)
			c.kind = KIND_CIRCLE;
		else if (sel < 52)
			c.kind = KIND_CLEAR;
		else
			c.kind = KIND_READ;
		if (c.kind == KIND_LINE && $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1))
				c.x_end = c.x_start;
			else
				c.y_end = c.y_start;
		end
		return c;
	endfunction

	// Stimulus: directed corners, then random commands with pressure phases.
	initial begin
		cmd_t c;
		@(posedge arst_n);
		@(posedge clk);
		send_word(make_word(KIND_READ, 0, 0, 0, 0, 0, MODE_SET), 1);
		send_word(make_word(KIND_LINE, 0, 0, 127, 63, 0, MODE_SET), 1);
		send_word(make_word(KIND_READ, 0, 0, 0, 0, 0, MODE_SET), 1);
		send_word(make_word(KIND_LINE, 255, 255, 0, 0, 0, MODE_TOGGLE), 1);
		send_word(make_word(KIND_LINE, 10, 0, 10, 63, 0, MODE_SET), 1);
		send_word(make_word(KIND_LINE, 10, 40, 10, 5, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_LINE, 127, 20, 0, 20, 0, MODE_TOGGLE_ALT), 1);
		send_word(make_word(KIND_LINE, 5, 7, 5, 7, 0, MODE_TOGGLE), 1);
		send_word(make_word(KIND_READ, 5, 7, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_LINE, 100, 60, 3, 2, 0, MODE_SET), 1);
		send_word(make_word(KIND_LINE, 3, 60, 120, 1, 0, MODE_TOGGLE), 1);
		send_word(make_word(KIND_CIRCLE, 64, 32, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 64, 32, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_CIRCLE, 2, 3, 0, 0, 10, MODE_CLEAR), 1);
		send_word(make_word(KIND_CIRCLE, 255, 255, 0, 0, 255, MODE_CLEAR), 1);
		send_word(make_word(KIND_CIRCLE, 64, 32, 0, 0, 30, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 64, 2, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 128, 0, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 0, 64, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 255, 255, 255, 255, 255, MODE_TOGGLE_ALT), 1);
		send_word(make_word(KIND_CLEAR, 0, 0, 0, 0, 0, MODE_CLEAR), 1);
		send_word(make_word(KIND_READ, 64, 2, 0, 0, 0, MODE_CLEAR), 1);
		for (int i = 0; i < 750; i++) begin
			if (i == 200) begin
				// Hold off results while commands keep coming.
				hold_rsp = 1'b1;
				for (int j = 0; j < 12; j++)
					send_word(random_word(), 0);
				hold_rsp = 1'b0;
			end
			if (i == 400 || i == 600)
				wait (pending_count == 0);
			c = random_word();
			send_word(c, (i % 100) >= 30);
		end
		stim_done = 1'b1;
	end

	// Result side: random stalls, a long hold-off when asked.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (hold_rsp)
				stall = 3000;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	// Watchdog on accepted words, and the end of run.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("watchdog expired with %0d results outstanding", pending_count);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_count == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d command words (%0d reads); lines, circles, clears, off-panel cases",
			words_sent, read_words);
		if (fail_count == 0 && pending_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
